FILE: sv/sleep_mode_controller_macros.svh
// Assertion macros for the sleep mode controller.
// Expects clk and rst_n in the scope of each use.
`ifndef SLEEP_MODE_CONTROLLER_MACROS_SVH
`define SLEEP_MODE_CONTROLLER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SMC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/smc_pkg.sv
// Shared types, codes and constants of the sleep mode controller.
// No dependencies.
`default_nettype none

package smc_pkg;

  localparam int unsigned MS_PER_SEC  = 1000;
  localparam int unsigned TMO_W       = 16;
  localparam int unsigned LIMIT_W     = 26;   // 65535 * 1000 fits in 26 bits
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned BLK_W       = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_SAVE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLEEP_TMO    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEP_SLEEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTER_REQ    = 2'd3;

  // beat function codes
  localparam logic FUNC_UPDATE   = 1'b0;
  localparam logic FUNC_ACTIVITY = 1'b1;

  // power modes
  localparam logic MODE_NORMAL = 1'b0;
  localparam logic MODE_IDLE   = 1'b1;

  // block reasons
  localparam logic [BLK_W-1:0] BLK_NONE         = 3'd0;
  localparam logic [BLK_W-1:0] BLK_LINK         = 3'd1;
  localparam logic [BLK_W-1:0] BLK_CHARGING     = 3'd2;
  localparam logic [BLK_W-1:0] BLK_SENSOR_TEST  = 3'd3;
  localparam logic [BLK_W-1:0] BLK_DISPLAY_TEST = 3'd4;
  localparam logic [BLK_W-1:0] BLK_DISPLAY_ON   = 3'd5;

  typedef struct packed {
    logic               power_save;
    logic [LIMIT_W-1:0] limit_ms;      // timeout * 1000, 0 disables
    logic               deep_sleep_en;
    logic               enter_req_en;
  } cfg_t;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] time_ms;
    logic              link_connected;
    logic              is_charging;
    logic              sensor_test_on;
    logic              display_test_on;
    logic              display_is_off;
  } item_t;

  typedef struct packed {
    logic             power_mode;
    logic [BLK_W-1:0] blocker;
    logic             mode_toggled;
    logic             armed_now;
    logic             armed_changed;
    logic             save_request;
    logic             enter_request;
    logic [CNT_W-1:0] idle_entries;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/sleep_mode_controller.sv
// Path: input beat to result beat through the input register, then the result register.
// Throughput: one beat per cycle while out_stall is low; the single 32-bit subtract-compare
// against the precomputed timeout in milliseconds sets the path between the two registers.
// Reset: synchronous active-low rst_n clears the configuration, all controller
// state and both valid flags; payload registers are not reset.
`default_nettype none

`include "sleep_mode_controller_macros.svh"

module sleep_mode_controller (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_wr_en,
  input  wire logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_func,
  input  wire logic [smc_pkg::TIME_W-1:0]      in_time_ms,
  input  wire logic                            in_link_connected,
  input  wire logic                            in_is_charging,
  input  wire logic                            in_sensor_test_on,
  input  wire logic                            in_display_test_on,
  input  wire logic                            in_display_is_off,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic                                 out_power_mode,
  output logic [smc_pkg::BLK_W-1:0]            out_blocker,
  output logic                                 out_mode_toggled,
  output logic                                 out_armed_now,
  output logic                                 out_armed_changed,
  output logic                                 out_save_request,
  output logic                                 out_enter_request,
  output logic [smc_pkg::CNT_W-1:0]            out_idle_entries
);
  import smc_pkg::*;

  cfg_t    cfg;
  item_t   item_r, item_nxt;
  logic    in_vld_r, in_vld_nxt;
  result_t res_r, res;
  logic    out_vld_r, out_vld_nxt;
  logic    in_ld, adv;

  smc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  smc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (adv),
    .item  (item_r),
    .res   (res)
  );

  // handshake: beat moves to the result register whenever that one is free
  assign adv        = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall   = in_vld_r && !adv;
  assign in_ld      = in_valid && !in_stall;
  assign in_vld_nxt = in_ld || (in_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  always_comb begin
    item_nxt.func            = in_func;
    item_nxt.time_ms         = in_time_ms;
    item_nxt.link_connected  = in_link_connected;
    item_nxt.is_charging     = in_is_charging;
    item_nxt.sensor_test_on  = in_sensor_test_on;
    item_nxt.display_test_on = in_display_test_on;
    item_nxt.display_is_off  = in_display_is_off;
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ld) item_r <= item_nxt;
    if (adv)   res_r  <= res;
  end

  assign out_valid         = out_vld_r;
  assign out_power_mode    = res_r.power_mode;
  assign out_blocker       = res_r.blocker;
  assign out_mode_toggled  = res_r.mode_toggled;
  assign out_armed_now     = res_r.armed_now;
  assign out_armed_changed = res_r.armed_changed;
  assign out_save_request  = res_r.save_request;
  assign out_enter_request = res_r.enter_request;
  assign out_idle_entries  = res_r.idle_entries;

  // requests only come out of an armed idle state
  `SMC_ASSERT_NOW(a_save_armed, out_valid && out_save_request, out_armed_now && out_power_mode, "save request while not armed in idle")
  `SMC_ASSERT_NOW(a_enter_armed, out_valid && out_enter_request, out_armed_now && out_power_mode, "enter request while not armed in idle")
  // a free result register never holds off the input side
  `SMC_ASSERT_NOW(a_no_false_stall, !out_valid || !out_stall, !in_stall, "input stalled while result register is free")

endmodule

`default_nettype wire

FILE: sv/smc_cfg.sv
// Configuration registers of the sleep mode controller.
// Depends on smc_pkg; precomputes the timeout in milliseconds on write.
`default_nettype none

module smc_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [smc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [smc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output smc_pkg::cfg_t                        cfg
);
  import smc_pkg::*;

  cfg_t               cfg_r, cfg_nxt;
  logic [LIMIT_W-1:0] limit_calc;

  // seconds to milliseconds, 16 x 10 bit product
  assign limit_calc = LIMIT_W'(cfg_wdata) * LIMIT_W'(MS_PER_SEC);

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_POWER_SAVE: cfg_nxt.power_save    = cfg_wdata[0];
        CFG_SLEEP_TMO:  cfg_nxt.limit_ms      = limit_calc;
        CFG_DEEP_SLEEP: cfg_nxt.deep_sleep_en = cfg_wdata[0];
        CFG_ENTER_REQ:  cfg_nxt.enter_req_en  = cfg_wdata[0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: sv/smc_core.sv
// Controller state and the single-pass next-state / result logic.
// Depends on smc_pkg and sleep_mode_controller_macros.svh.
`default_nettype none

`include "sleep_mode_controller_macros.svh"

module smc_core (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire smc_pkg::cfg_t cfg,
  input  wire logic     fire,      // beat in the input register is processed
  input  wire smc_pkg::item_t item,
  output smc_pkg::result_t res
);
  import smc_pkg::*;

  logic              mode_r, mode_nxt;
  logic              armed_r, armed_nxt;
  logic              save_done_r, save_done_nxt;
  logic              trk_r, trk_nxt;
  logic [TIME_W-1:0] since_r, since_nxt;
  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic [BLK_W-1:0]  blk_pick;
  logic [TIME_W-1:0] elapsed;
  logic              reached;
  logic              tmo_on;
  logic              armed_keep, save_keep;
  logic              go_idle;
  logic              save_req, enter_req;

  // block reason by fixed priority
  always_comb begin
    if (item.link_connected)       blk_pick = BLK_LINK;
    else if (item.is_charging)     blk_pick = BLK_CHARGING;
    else if (item.sensor_test_on)  blk_pick = BLK_SENSOR_TEST;
    else if (item.display_test_on) blk_pick = BLK_DISPLAY_TEST;
    else if (!item.display_is_off) blk_pick = BLK_DISPLAY_ON;
    else                           blk_pick = BLK_NONE;
  end

  // display-off tracking, then elapsed time against the precomputed limit
  always_comb begin
    if (item.display_is_off) begin
      trk_nxt    = 1'b1;
      since_nxt  = trk_r ? since_r : item.time_ms;
      armed_keep = armed_r;
      save_keep  = save_done_r;
    end else begin
      trk_nxt    = 1'b0;
      since_nxt  = since_r;
      armed_keep = 1'b0;
      save_keep  = 1'b0;
    end
    if (item.func == FUNC_ACTIVITY) begin
      trk_nxt   = 1'b0;
      since_nxt = item.time_ms;
    end
  end

  assign elapsed = item.time_ms - since_nxt;
  assign reached = elapsed >= TIME_W'(cfg.limit_ms);
  assign tmo_on  = (cfg.limit_ms != '0) && trk_nxt && reached;
  assign go_idle = cfg.power_save || tmo_on;

  // mode, arming and request decisions
  always_comb begin
    mode_nxt      = mode_r;
    armed_nxt     = armed_r;
    save_done_nxt = save_done_r;
    blk_nxt       = blk_r;
    cnt_nxt       = cnt_r;
    save_req      = 1'b0;
    enter_req     = 1'b0;
    if (item.func == FUNC_ACTIVITY) begin
      if (mode_r == MODE_IDLE) save_done_nxt = 1'b0;
      mode_nxt  = MODE_NORMAL;
      armed_nxt = 1'b0;
    end else begin
      blk_nxt = blk_pick;
      if (blk_pick != BLK_NONE) begin
        mode_nxt      = MODE_NORMAL;
        armed_nxt     = armed_keep;
        save_done_nxt = save_keep;
      end else if (go_idle) begin
        if (mode_r != MODE_IDLE) cnt_nxt = cnt_r + CNT_W'(1);
        mode_nxt      = MODE_IDLE;
        armed_nxt     = tmo_on;
        save_req      = tmo_on && cfg.deep_sleep_en && !save_keep;
        save_done_nxt = save_keep || save_req;
        enter_req     = tmo_on && cfg.deep_sleep_en && cfg.enter_req_en;
      end else begin
        mode_nxt      = MODE_NORMAL;
        armed_nxt     = 1'b0;
        save_done_nxt = 1'b0;
      end
    end
  end

  // result fields for this beat
  always_comb begin
    res.power_mode    = mode_nxt;
    res.blocker       = blk_nxt;
    res.mode_toggled  = mode_nxt != mode_r;
    res.armed_now     = armed_nxt;
    res.armed_changed = armed_nxt != armed_r;
    res.save_request  = save_req;
    res.enter_request = enter_req;
    res.idle_entries  = cnt_nxt;
  end

  // state update once per processed beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_NORMAL;
      armed_r     <= 1'b0;
      save_done_r <= 1'b0;
      trk_r       <= 1'b0;
      since_r     <= '0;
      blk_r       <= BLK_NONE;
      cnt_r       <= '0;
    end else if (fire) begin
      mode_r      <= mode_nxt;
      armed_r     <= armed_nxt;
      save_done_r <= save_done_nxt;
      trk_r       <= trk_nxt;
      since_r     <= since_nxt;
      blk_r       <= blk_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // a save request is only raised once until the flag is cleared
  `SMC_ASSERT_NEXT(a_save_once, fire && save_req, save_done_r, "save request without save flag set")
  // counter moves only on an entry into idle
  `SMC_ASSERT_NEXT(a_cnt_step, fire && (cnt_nxt != cnt_r), mode_r == MODE_IDLE && cnt_r == $past(cnt_r) + CNT_W'(1), "idle entry count stepped without entering idle")

endmodule

`default_nettype wire
